FILE: rtl/bib_pkg.sv
// Package for the bounded integer binarizer: microcode types, step addresses,
// context bases and the control program table.
// No dependencies.
`timescale 1ns / 1ps

package bib_pkg;

  // Field widths of the items.
  localparam int VAL_W   = 11;
  localparam int MAG_W   = 10;
  localparam int EXP_W   = 4;
  localparam int PREC_W  = 4;
  localparam int CTX_W   = 5;
  localparam int FIELD_MAG = 1023;

  // Base context index of each kind of decision.
  localparam logic [CTX_W-1:0] CTX_ZERO = 5'd0;
  localparam logic [CTX_W-1:0] CTX_EXP  = 5'd1;
  localparam logic [CTX_W-1:0] CTX_SIGN = 5'd11;
  localparam logic [CTX_W-1:0] CTX_MANT = 5'd21;

  // Datapath operations, one per control word.
  typedef enum logic [3:0] {
    OP_IDLE,
    OP_SAT,
    OP_CLAMP,
    OP_MAGS,
    OP_LOGS,
    OP_ZFLAG,
    OP_EXP,
    OP_EXPEND,
    OP_SIGN,
    OP_MINIT,
    OP_MANT,
    OP_FIN
  } op_t;

  // Jump conditions; when false the step counter advances by one, unless stalled.
  typedef enum logic [2:0] {
    C_NEXT,
    C_NO_INPUT,
    C_BAD_RANGE,
    C_V_ZERO,
    C_CNT_LT_E,
    C_E_ZERO,
    C_CNT_NZ,
    C_ALWAYS
  } cond_t;

  typedef logic [3:0] step_t;

  // Step addresses of the program.
  localparam step_t STEP_IDLE   = 4'd0;
  localparam step_t STEP_SAT    = 4'd1;
  localparam step_t STEP_CLAMP  = 4'd2;
  localparam step_t STEP_MAGS   = 4'd3;
  localparam step_t STEP_LOGS   = 4'd4;
  localparam step_t STEP_ZFLAG  = 4'd5;
  localparam step_t STEP_EXP    = 4'd6;
  localparam step_t STEP_EXPEND = 4'd7;
  localparam step_t STEP_SIGN   = 4'd8;
  localparam step_t STEP_MINIT  = 4'd9;
  localparam step_t STEP_MANT   = 4'd10;
  localparam step_t STEP_FIN    = 4'd11;

  // One control word.
  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } uword_t;

  // Status flags from the datapath to the sequencer.
  typedef struct packed {
    logic stall;
    logic bad_range;
    logic v_zero;
    logic cnt_lt_e;
    logic e_zero;
    logic cnt_nz;
  } dp_status_t;

  // The control program.
  function automatic uword_t prog_rom(input step_t pc);
    uword_t w;
    unique case (pc)
      STEP_IDLE:   w = '{OP_IDLE,   C_NO_INPUT,  STEP_IDLE};
      STEP_SAT:    w = '{OP_SAT,    C_NEXT,      STEP_IDLE};
      STEP_CLAMP:  w = '{OP_CLAMP,  C_BAD_RANGE, STEP_FIN};
      STEP_MAGS:   w = '{OP_MAGS,   C_NEXT,      STEP_IDLE};
      STEP_LOGS:   w = '{OP_LOGS,   C_NEXT,      STEP_IDLE};
      STEP_ZFLAG:  w = '{OP_ZFLAG,  C_V_ZERO,    STEP_FIN};
      STEP_EXP:    w = '{OP_EXP,    C_CNT_LT_E,  STEP_EXP};
      STEP_EXPEND: w = '{OP_EXPEND, C_NEXT,      STEP_IDLE};
      STEP_SIGN:   w = '{OP_SIGN,   C_NEXT,      STEP_IDLE};
      STEP_MINIT:  w = '{OP_MINIT,  C_E_ZERO,    STEP_FIN};
      STEP_MANT:   w = '{OP_MANT,   C_CNT_NZ,    STEP_MANT};
      STEP_FIN:    w = '{OP_FIN,    C_ALWAYS,    STEP_IDLE};
      default:     w = '{OP_IDLE,   C_ALWAYS,    STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/bounded_integer_binarizer_encode_top.sv
// Bounded integer binarizer, exponent/mantissa/sign form: one symbol in, up to
// 20 tagged decisions out. Symbols are taken one at a time, only in the idle step;
// an empty range or a zero value ends a symbol's program early. Output
// back-pressure stalls the sequencer. Each decision waits in a hold stage until
// the next one exists or the symbol ends; at most one decision per cycle.
// Synchronous active-low reset empties the output and returns to the idle step.
`timescale 1ns / 1ps

module bounded_integer_binarizer_encode_top #(
  parameter int MAX_EXPONENT = 9
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // value[10:0], range_low[21:11], range_high[32:22], precision[36:33], zero pad
  input  logic [39:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // context_index[4:0], decision_bit[5], update_only[6], coded_value[17:7], pad
  output logic [23:0] out_tdata,
  output logic        out_tlast
);
  import bib_pkg::*;

  uword_t     uword;
  dp_status_t status;

  // Program sequencer.
  bib_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .status   (status),
    .uword    (uword),
    .in_ready (in_tready)
  );

  // Datapath driven by the control word.
  bib_datapath #(
    .MAX_EXPONENT(MAX_EXPONENT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .uword     (uword),
    .in_tvalid (in_tvalid),
    .in_tdata  (in_tdata),
    .status    (status),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

endmodule

FILE: rtl/bib_seq.sv
// Microcode sequencer: step counter, program table fetch and conditional jumps.
// Depends on bib_pkg.
`timescale 1ns / 1ps

module bib_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  bib_pkg::dp_status_t status,
  output bib_pkg::uword_t     uword,
  output logic                in_ready
);
  import bib_pkg::*;

  step_t pc_r;
  step_t pc_nxt;
  logic  take;

  // Fetch the control word of the current step.
  assign uword    = prog_rom(pc_r);
  assign in_ready = (uword.op == OP_IDLE);

  // Evaluate the jump condition.
  always_comb begin
    unique case (uword.cond)
      C_NEXT:      take = 1'b0;
      C_NO_INPUT:  take = !in_tvalid;
      C_BAD_RANGE: take = status.bad_range;
      C_V_ZERO:    take = status.v_zero;
      C_CNT_LT_E:  take = status.cnt_lt_e;
      C_E_ZERO:    take = status.e_zero;
      C_CNT_NZ:    take = status.cnt_nz;
      C_ALWAYS:    take = 1'b1;
      default:     take = 1'b1;
    endcase
    if (status.stall) begin
      pc_nxt = pc_r;
    end else if (take) begin
      pc_nxt = uword.target;
    end else begin
      pc_nxt = pc_r + 4'd1;
    end
  end

  // Step counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= STEP_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

FILE: rtl/bib_datapath.sv
// Datapath of the binarizer: operand registers, magnitude and exponent logic,
// mantissa bit decisions, a one-item hold stage and the output register.
// Depends on bib_pkg.
`timescale 1ns / 1ps

module bib_datapath #(
  parameter int MAX_EXPONENT = 9
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bib_pkg::uword_t      uword,
  input  logic                 in_tvalid,
  input  logic [39:0]          in_tdata,
  output bib_pkg::dp_status_t  status,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [23:0]          out_tdata,
  output logic                 out_tlast
);
  import bib_pkg::*;

  localparam int MAG_LIMIT = (MAX_EXPONENT >= 9) ? FIELD_MAG : ((1 << (MAX_EXPONENT + 1)) - 1);
  localparam logic signed [VAL_W-1:0] LIM_POS = VAL_W'(MAG_LIMIT);
  localparam logic signed [VAL_W-1:0] LIM_NEG = -LIM_POS;

  // Index of the leading one; zero for zero and one.
  function automatic logic [EXP_W-1:0] flog2(input logic [MAG_W-1:0] x);
    logic [EXP_W-1:0] r;
    r = '0;
    for (int k = 1; k < MAG_W; k++) begin
      if (x[k]) r = EXP_W'(k);
    end
    return r;
  endfunction

  function automatic logic signed [VAL_W-1:0] sat(input logic signed [VAL_W-1:0] x);
    return (x > LIM_POS) ? LIM_POS : ((x < LIM_NEG) ? LIM_NEG : x);
  endfunction

  function automatic logic [MAG_W-1:0] absv(input logic signed [VAL_W-1:0] x);
    return x[VAL_W-1] ? MAG_W'(-x) : MAG_W'(x);
  endfunction

  // Operand and working registers.
  logic signed [VAL_W-1:0] v_r, lo_r, hi_r;
  logic [PREC_W-1:0]       p_r;
  logic [MAG_W-1:0]        alo_r, ahi_r, amax_r, amin_r, a_r, mymax_r;
  logic [MAG_W-1:0]        run_r, left_r;
  logic                    spans_r, vneg_r, vzero_r, aminz_r;
  logic [EXP_W-1:0]        e_r, bmin_r, bmax_r, cnt_r;

  // Hold stage and output register.
  logic                    hold_v_r;
  logic [CTX_W-1:0]        hold_ctx_r;
  logic                    hold_bit_r, hold_upd_r;
  logic                    out_v_r, out_bit_r, out_upd_r, out_last_r;
  logic [CTX_W-1:0]        out_ctx_r;
  logic signed [VAL_W-1:0] out_coded_r;

  logic                    accept, stall, emit, dbit, dupd, mbit, push;
  logic [CTX_W-1:0]        dctx;
  logic [MAG_W-1:0]        bitm, left_nxt;
  logic [MAG_W:0]          sum_one, sum_left;
  logic [CTX_W-1:0]        ip_sum;
  logic signed [VAL_W-1:0] coded;

  assign accept = (uword.op == OP_IDLE) && in_tvalid;
  assign stall  = hold_v_r && out_v_r && !out_tready;

  assign status.stall     = stall;
  assign status.bad_range = (lo_r >= hi_r);
  assign status.v_zero    = vzero_r;
  assign status.cnt_lt_e  = (cnt_r < e_r);
  assign status.e_zero    = (e_r == '0);
  assign status.cnt_nz    = (cnt_r != '0);

  // Mantissa bit arithmetic for the current bit position.
  assign bitm     = MAG_W'(1) << cnt_r;
  assign left_nxt = left_r ^ bitm;
  assign sum_one  = {1'b0, run_r} + {1'b0, bitm};
  assign sum_left = {1'b0, run_r} + {1'b0, left_nxt};
  assign ip_sum   = {1'b0, cnt_r} + {1'b0, p_r};
  assign coded    = vneg_r ? -$signed({1'b0, run_r}) : $signed({1'b0, run_r});

  // Decision produced by the current step, if any.
  always_comb begin
    emit = 1'b0;
    dctx = CTX_ZERO;
    dbit = 1'b0;
    dupd = 1'b0;
    mbit = 1'b0;
    unique case (uword.op)
      OP_ZFLAG: begin
        if (vzero_r) begin
          emit = 1'b1;
          dbit = 1'b1;
        end else if (aminz_r) begin
          emit = 1'b1;
        end
      end
      OP_EXP: begin
        emit = (cnt_r < e_r);
        dctx = CTX_EXP + CTX_W'(cnt_r);
        dbit = 1'b1;
      end
      OP_EXPEND: begin
        emit = (e_r < bmax_r);
        dctx = CTX_EXP + CTX_W'(e_r);
      end
      OP_SIGN: begin
        emit = spans_r;
        dctx = CTX_SIGN + CTX_W'(e_r);
        dbit = vneg_r;
      end
      OP_MANT: begin
        dctx = CTX_MANT + CTX_W'(cnt_r);
        if (sum_one > {1'b0, mymax_r}) begin
          emit = 1'b1;
          dupd = 1'b1;
        end else if (sum_left < {1'b0, amin_r}) begin
          emit = 1'b1;
          dbit = 1'b1;
          dupd = 1'b1;
          mbit = 1'b1;
        end else if (ip_sum >= {1'b0, e_r}) begin
          emit = 1'b1;
          dbit = a_r[cnt_r];
          mbit = a_r[cnt_r];
        end else if (ip_sum + CTX_W'(1) == {1'b0, e_r}) begin
          mbit = 1'b1;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // The held decision moves on once the next one exists or the symbol ends.
  assign push = !stall && hold_v_r && (emit || uword.op == OP_FIN);

  // Operand and working registers, one operation per step.
  always_ff @(posedge clk) begin
    if (accept) begin
      v_r  <= in_tdata[10:0];
      lo_r <= in_tdata[21:11];
      hi_r <= in_tdata[32:22];
      p_r  <= in_tdata[36:33];
    end
    if (!stall) begin
      unique case (uword.op)
        OP_SAT: begin
          v_r  <= sat(v_r);
          lo_r <= sat(lo_r);
          hi_r <= sat(hi_r);
        end
        OP_CLAMP: begin
          v_r     <= (v_r < lo_r) ? lo_r : ((v_r > hi_r) ? hi_r : v_r);
          alo_r   <= absv(lo_r);
          ahi_r   <= absv(hi_r);
          spans_r <= (lo_r < 0) && (hi_r > 0);
          aminz_r <= (hi_r >= 0) && (lo_r <= 0);
        end
        OP_MAGS: begin
          a_r     <= absv(v_r);
          vneg_r  <= v_r[VAL_W-1];
          vzero_r <= (v_r == '0);
          amax_r  <= (ahi_r > alo_r) ? ahi_r : alo_r;
          amin_r  <= aminz_r ? '0 : ((ahi_r < alo_r) ? ahi_r : alo_r);
          mymax_r <= spans_r ? ((v_r > 0) ? ahi_r : alo_r)
                             : ((ahi_r > alo_r) ? ahi_r : alo_r);
          run_r   <= '0;
        end
        OP_LOGS: begin
          e_r    <= flog2(a_r);
          bmin_r <= flog2(amin_r);
          bmax_r <= flog2(amax_r);
        end
        OP_ZFLAG: begin
          cnt_r <= bmin_r;
        end
        OP_EXP: begin
          if (cnt_r < e_r) cnt_r <= cnt_r + EXP_W'(1);
        end
        OP_MINIT: begin
          run_r  <= MAG_W'(1) << e_r;
          left_r <= (MAG_W'(1) << e_r) - MAG_W'(1);
          cnt_r  <= e_r - EXP_W'(1);
        end
        OP_MANT: begin
          run_r  <= run_r | (mbit ? bitm : '0);
          left_r <= left_nxt;
          cnt_r  <= cnt_r - EXP_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // Hold stage and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (!stall) begin
        if (emit) begin
          hold_v_r   <= 1'b1;
          hold_ctx_r <= dctx;
          hold_bit_r <= dbit;
          hold_upd_r <= dupd;
        end else if (uword.op == OP_FIN) begin
          hold_v_r <= 1'b0;
        end
      end
      if (push) begin
        out_v_r     <= 1'b1;
        out_ctx_r   <= hold_ctx_r;
        out_bit_r   <= hold_bit_r;
        out_upd_r   <= hold_upd_r;
        out_last_r  <= (uword.op == OP_FIN);
        out_coded_r <= (uword.op == OP_FIN) ? coded : '0;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {6'd0, out_coded_r, out_upd_r, out_bit_r, out_ctx_r};

endmodule
